// ----- src/stri_pkg.sv -----
// shared constants and types for the segment-triangle intersection block
// no dependencies
package stri_pkg;

  localparam int FIELD_W    = 63;
  localparam int SCALE_BITS = 16;
  localparam int BARY_OUT_W = 17;
  localparam int NORM_OUT_W = 45;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd1311;

  // control that travels with each item out of the front end
  typedef struct packed {
    logic valid;
    logic ok;
  } front_ctl_t;

endpackage

// ----- src/segment_triangle_intersect.sv -----
// segment-triangle intersection top level: register, hit test, dividers, output stage
// depends on stri_pkg, stri_front, stri_div
//
// usage:
//   an item (particle position and velocity plus three vertices) is taken at
//   every clock edge with start high and busy low; busy is high only while
//   reset is held, so one item can enter in every cycle
//   each item gives one result, shown for one cycle with out_strobe high,
//   after it has passed five geometry stages, one hit-test stage,
//   BARY_BITS + 1 divider stages (one quotient bit per stage) and the
//   output register
//   results come out in the order the items went in; the receiver cannot stall
//   and the pipeline never stops
//   the step_scale register is written through cfg_valid/cfg_ready (ready is
//   high outside reset); write it only with the pipeline empty
//   reset clears all valid bits, so no result is shown afterwards until a new
//   item arrives, and sets step_scale to 1311
module segment_triangle_intersect #(
  parameter int COORD_BITS = 21,
  parameter int BARY_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [stri_pkg::FIELD_W-1:0]           in_particle_pos,
  input  logic [stri_pkg::FIELD_W-1:0]           in_particle_vel,
  input  logic [stri_pkg::FIELD_W-1:0]           in_vertex_a,
  input  logic [stri_pkg::FIELD_W-1:0]           in_vertex_b,
  input  logic [stri_pkg::FIELD_W-1:0]           in_vertex_c,
  output logic                                   out_strobe,
  output logic                                   out_hit,
  output logic [stri_pkg::BARY_OUT_W-1:0]        out_bary_u,
  output logic [stri_pkg::BARY_OUT_W-1:0]        out_bary_v,
  output logic [stri_pkg::BARY_OUT_W-1:0]        out_bary_w,
  output logic signed [stri_pkg::NORM_OUT_W-1:0] out_normal_x,
  output logic signed [stri_pkg::NORM_OUT_W-1:0] out_normal_y,
  output logic signed [stri_pkg::NORM_OUT_W-1:0] out_normal_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [stri_pkg::SCALE_BITS-1:0]        cfg_data
);

  localparam int CW = COORD_BITS + 1;
  localparam int NW = 2 * CW + 1;
  localparam int DW = CW + NW + 2;
  localparam int QW = BARY_BITS + 1;
  localparam logic [QW-1:0] ONE = QW'(1) << BARY_BITS;

  logic [stri_pkg::SCALE_BITS-1:0] scale_r;

  stri_pkg::front_ctl_t  fctl;
  logic signed [DW-1:0]  d_val;
  logic signed [DW-1:0]  v_val;
  logic signed [DW-1:0]  w_val;
  logic signed [NW-1:0]  n_val [3];

  logic                  v6_r;
  logic                  hit6_r;
  logic signed [DW-1:0]  d6_r;
  logic signed [DW-1:0]  vv6_r;
  logic signed [DW-1:0]  ww6_r;
  logic signed [NW-1:0]  n6_r [3];

  logic                  vd_r   [QW];
  logic                  hitd_r [QW];
  logic signed [NW-1:0]  nd_r   [QW][3];

  logic [QW-1:0]         qv;
  logic [QW-1:0]         qw;
  logic [QW-1:0]         qu;
  logic signed [DW:0]    vw_sum;
  logic                  hit_nxt;

  logic                  strobe_r;
  logic                  hit_r;
  logic [stri_pkg::BARY_OUT_W-1:0] bu_r, bv_r, bw_r;
  logic signed [NW-1:0]  nout_r [3];

  // nothing is taken on a reset edge
  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= stri_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      scale_r <= cfg_data;
    end
  end

  stri_front #(.COORD_BITS(COORD_BITS), .CW(CW), .NW(NW), .DW(DW)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (start),
    .in_particle_pos (in_particle_pos),
    .in_particle_vel (in_particle_vel),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .in_vertex_c     (in_vertex_c),
    .step_scale      (scale_r),
    .ctl             (fctl),
    .d_val           (d_val),
    .v_val           (v_val),
    .w_val           (w_val),
    .n_val           (n_val)
  );

  // barycentric bounds against d
  always_comb begin
    vw_sum  = (DW + 1)'(v_val) + (DW + 1)'(w_val);
    hit_nxt = fctl.ok && !v_val[DW-1] && (v_val <= d_val) && !w_val[DW-1]
              && (vw_sum <= (DW + 1)'(d_val));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= fctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    hit6_r <= hit_nxt;
    d6_r   <= d_val;
    vv6_r  <= v_val;
    ww6_r  <= w_val;
    n6_r   <= n_val;
  end

  stri_div #(.DW(DW), .QB(BARY_BITS)) u_div_v (
    .clk (clk),
    .x   ($unsigned(vv6_r)),
    .d   ($unsigned(d6_r)),
    .q   (qv)
  );

  stri_div #(.DW(DW), .QB(BARY_BITS)) u_div_w (
    .clk (clk),
    .x   ($unsigned(ww6_r)),
    .d   ($unsigned(d6_r)),
    .q   (qw)
  );

  // side data follows the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else begin
      vd_r[0] <= v6_r;
      for (int i = 1; i < QW; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    hitd_r[0] <= hit6_r;
    nd_r[0]   <= n6_r;
    for (int i = 1; i < QW; i++) begin
      hitd_r[i] <= hitd_r[i-1];
      nd_r[i]   <= nd_r[i-1];
    end
  end

  assign qu = ONE - qv - qw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vd_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hitd_r[QW-1];
    nout_r <= nd_r[QW-1];
    if (hitd_r[QW-1]) begin
      bu_r <= stri_pkg::BARY_OUT_W'(qu);
      bv_r <= stri_pkg::BARY_OUT_W'(qv);
      bw_r <= stri_pkg::BARY_OUT_W'(qw);
    end else begin
      bu_r <= '0;
      bv_r <= '0;
      bw_r <= '0;
    end
  end

  assign out_strobe   = strobe_r;
  assign out_hit      = hit_r;
  assign out_bary_u   = bu_r;
  assign out_bary_v   = bv_r;
  assign out_bary_w   = bw_r;
  assign out_normal_x = stri_pkg::NORM_OUT_W'(nout_r[0]);
  assign out_normal_y = stri_pkg::NORM_OUT_W'(nout_r[1]);
  assign out_normal_z = stri_pkg::NORM_OUT_W'(nout_r[2]);

endmodule

// ----- src/stri_front.sv -----
// geometry front end: segment end, face normal, dot and cross products, d/t test
// five register stages; depends on stri_pkg
module stri_front #(
  parameter int COORD_BITS = 21,
  parameter int CW = COORD_BITS + 1,
  parameter int NW = 2 * CW + 1,
  parameter int DW = CW + NW + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [stri_pkg::FIELD_W-1:0]   in_particle_pos,
  input  logic [stri_pkg::FIELD_W-1:0]   in_particle_vel,
  input  logic [stri_pkg::FIELD_W-1:0]   in_vertex_a,
  input  logic [stri_pkg::FIELD_W-1:0]   in_vertex_b,
  input  logic [stri_pkg::FIELD_W-1:0]   in_vertex_c,
  input  logic [stri_pkg::SCALE_BITS-1:0] step_scale,
  output stri_pkg::front_ctl_t           ctl,
  output logic signed [DW-1:0]           d_val,
  output logic signed [DW-1:0]           v_val,
  output logic signed [DW-1:0]           w_val,
  output logic signed [NW-1:0]           n_val [3]
);

  localparam int PW = CW + NW;
  localparam int MW = COORD_BITS + stri_pkg::SCALE_BITS + 1;
  localparam logic signed [MW:0] HALF = (MW + 1)'(1) <<< (stri_pkg::SCALE_BITS - 1);

  function automatic logic signed [CW-1:0] crd(input logic [stri_pkg::FIELD_W-1:0] f,
                                               input int k);
    crd = CW'($signed(f[k*COORD_BITS +: COORD_BITS]));
  endfunction

  // stage 1
  logic                  v1_r;
  logic signed [CW-1:0]  ab1_r [3];
  logic signed [CW-1:0]  ac1_r [3];
  logic signed [CW-1:0]  ap1_r [3];
  logic signed [MW-1:0]  prod1_r [3];
  // stage 2
  logic                  v2_r;
  logic signed [CW-1:0]  ab2_r [3];
  logic signed [CW-1:0]  ac2_r [3];
  logic signed [CW-1:0]  ap2_r [3];
  logic signed [CW-1:0]  qp2_r [3];
  logic signed [NW-1:0]  n2_r [3];
  // stage 3
  logic                  v3_r;
  logic signed [CW-1:0]  ab3_r [3];
  logic signed [CW-1:0]  ac3_r [3];
  logic signed [NW-1:0]  n3_r [3];
  logic signed [NW-1:0]  e3_r [3];
  logic signed [PW-1:0]  dp3_r [3];
  logic signed [PW-1:0]  tp3_r [3];
  // stage 4
  logic                  v4_r;
  logic signed [NW-1:0]  n4_r [3];
  logic signed [DW-1:0]  d4_r;
  logic signed [DW-1:0]  t4_r;
  logic signed [PW-1:0]  vp4_r [3];
  logic signed [PW-1:0]  wp4_r [3];
  // stage 5
  stri_pkg::front_ctl_t  ctl5_r;
  logic signed [NW-1:0]  n5_r [3];
  logic signed [DW-1:0]  d5_r;
  logic signed [DW-1:0]  v5_r;
  logic signed [DW-1:0]  w5_r;

  logic signed [MW:0]    rnd [3];
  logic signed [DW-1:0]  vsum;
  logic signed [DW-1:0]  wsum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = (MW + 1)'(prod1_r[k]) + HALF;
    end
    vsum = DW'(vp4_r[0]) + DW'(vp4_r[1]) + DW'(vp4_r[2]);
    wsum = DW'(wp4_r[0]) + DW'(wp4_r[1]) + DW'(wp4_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      ctl5_r <= '0;
    end else begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      ctl5_r.valid <= v4_r;
      ctl5_r.ok    <= (d4_r > 0) && !t4_r[DW-1] && (t4_r <= d4_r);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ab1_r[k]   <= crd(in_vertex_b, k) - crd(in_vertex_a, k);
      ac1_r[k]   <= crd(in_vertex_c, k) - crd(in_vertex_a, k);
      ap1_r[k]   <= crd(in_particle_pos, k) - crd(in_vertex_a, k);
      prod1_r[k] <= MW'($signed(in_particle_vel[k*COORD_BITS +: COORD_BITS]))
                    * $signed(MW'(step_scale));

      ab2_r[k] <= ab1_r[k];
      ac2_r[k] <= ac1_r[k];
      ap2_r[k] <= ap1_r[k];
      // p - q is minus the rounded step
      qp2_r[k] <= -$signed(rnd[k][stri_pkg::SCALE_BITS +: CW]);

      ab3_r[k] <= ab2_r[k];
      ac3_r[k] <= ac2_r[k];
      n3_r[k]  <= n2_r[k];
      dp3_r[k] <= PW'(qp2_r[k]) * PW'(n2_r[k]);
      tp3_r[k] <= PW'(ap2_r[k]) * PW'(n2_r[k]);

      n4_r[k]  <= n3_r[k];
      vp4_r[k] <= PW'(ac3_r[k]) * PW'(e3_r[k]);
      wp4_r[k] <= PW'(ab3_r[k]) * PW'(e3_r[k]);

      n5_r[k] <= n4_r[k];
    end
    n2_r[0] <= NW'(ab1_r[1]) * NW'(ac1_r[2]) - NW'(ab1_r[2]) * NW'(ac1_r[1]);
    n2_r[1] <= NW'(ab1_r[2]) * NW'(ac1_r[0]) - NW'(ab1_r[0]) * NW'(ac1_r[2]);
    n2_r[2] <= NW'(ab1_r[0]) * NW'(ac1_r[1]) - NW'(ab1_r[1]) * NW'(ac1_r[0]);

    e3_r[0] <= NW'(qp2_r[1]) * NW'(ap2_r[2]) - NW'(qp2_r[2]) * NW'(ap2_r[1]);
    e3_r[1] <= NW'(qp2_r[2]) * NW'(ap2_r[0]) - NW'(qp2_r[0]) * NW'(ap2_r[2]);
    e3_r[2] <= NW'(qp2_r[0]) * NW'(ap2_r[1]) - NW'(qp2_r[1]) * NW'(ap2_r[0]);

    d4_r <= DW'(dp3_r[0]) + DW'(dp3_r[1]) + DW'(dp3_r[2]);
    t4_r <= DW'(tp3_r[0]) + DW'(tp3_r[1]) + DW'(tp3_r[2]);

    d5_r <= d4_r;
    v5_r <= vsum;
    w5_r <= -wsum;
  end

  assign ctl   = ctl5_r;
  assign d_val = d5_r;
  assign v_val = v5_r;
  assign w_val = w5_r;
  assign n_val = n5_r;

endmodule

// ----- src/stri_div.sv -----
// pipelined restoring divider: floor(x * 2^QB / d) for 0 <= x <= d, one bit per stage
// no dependencies
module stri_div #(
  parameter int DW = 69,
  parameter int QB = 16
) (
  input  logic          clk,
  input  logic [DW-1:0] x,
  input  logic [DW-1:0] d,
  output logic [QB:0]   q
);

  logic [DW-1:0] rem_r [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic [QB:0]   q_r   [QB+1];

  always_ff @(posedge clk) begin
    den_r[0] <= d;
    if (x >= d) begin
      rem_r[0] <= x - d;
      q_r[0]   <= (QB + 1)'(1);
    end else begin
      rem_r[0] <= x;
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DW-1:0] sh;
    logic          ge;
    assign sh = {rem_r[i-1][DW-2:0], 1'b0};
    assign ge = sh >= den_r[i-1];
    always_ff @(posedge clk) begin
      den_r[i] <= den_r[i-1];
      rem_r[i] <= ge ? sh - den_r[i-1] : sh;
      q_r[i]   <= {q_r[i-1][QB-1:0], ge};
    end
  end

  assign q = q_r[QB];

endmodule

// ----- src/stri_chk.sv -----
// port-level checks for segment_triangle_intersect, attached by bind
// depends on stri_pkg
module stri_chk #(
  parameter int BARY_BITS = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input logic                            out_hit,
  input logic [stri_pkg::BARY_OUT_W-1:0] out_bary_u,
  input logic [stri_pkg::BARY_OUT_W-1:0] out_bary_v,
  input logic [stri_pkg::BARY_OUT_W-1:0] out_bary_w
);

  localparam int LAT = BARY_BITS + 8;
  localparam logic [stri_pkg::BARY_OUT_W+1:0] ONE = (stri_pkg::BARY_OUT_W + 2)'(1) << BARY_BITS;

  // pipeline never refuses an item
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every result traces back to an item taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result without matching item");

  // a miss carries zero weights
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |-> (out_bary_u == '0 && out_bary_v == '0 && out_bary_w == '0))
    else $error("nonzero weights on a miss");

  // weights of a hit add up to one (checked only when BARY_BITS is at most 16)
  a_hit_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_hit) |-> ((BARY_BITS > 16) ||
      ((stri_pkg::BARY_OUT_W + 2)'(out_bary_u) + (stri_pkg::BARY_OUT_W + 2)'(out_bary_v)
       + (stri_pkg::BARY_OUT_W + 2)'(out_bary_w) == ONE)))
    else $error("weights do not sum to one");

  // flushed pipeline right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(!rst_n) |-> !out_strobe)
    else $error("result right after reset");

endmodule

bind segment_triangle_intersect stri_chk #(.BARY_BITS(BARY_BITS)) u_stri_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_hit    (out_hit),
  .out_bary_u (out_bary_u),
  .out_bary_v (out_bary_v),
  .out_bary_w (out_bary_w)
);
